// ===== design/ssc_pkg.sv =====
// Package for the Strauss surface coefficient unit: fixed-point constants,
// the divider stage payload type and the restoring division step.
// No dependencies.
package ssc_pkg;

    // Q.16 unity and the saturation limits of the Q3.16 results.
    localparam logic [16:0] Q16_ONE = 17'd65536;
    localparam logic signed [19:0] T_MAX = 20'sd524287;
    localparam logic signed [19:0] T_MIN = -20'sd524288;

    // The quotient is resolved one bit per stage below the saturation point.
    localparam int DIV_STEPS = 19;
    localparam int FRONT_STAGES = 6;

    // Payload carried through the divider stages.
    typedef struct packed {
        logic [16:0]        rem;
        logic [18:0]        pbits;
        logic [18:0]        quo;
        logic [16:0]        den;
        logic [16:0]        diffuse;
        logic               sat;
        logic               fault;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] rz;
    } div_stage_t;

    // One restoring division step: bring in the next dividend bit, subtract
    // the divisor when it fits, and shift the quotient bit in.
    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t  r;
        logic [17:0] trial;
        r     = s;
        trial = {s.rem, s.pbits[18]};
        if (trial >= {1'b0, s.den}) begin
            r.rem = 17'(trial - {1'b0, s.den});
            r.quo = {s.quo[17:0], 1'b1};
        end else begin
            r.rem = trial[16:0];
            r.quo = {s.quo[17:0], 1'b0};
        end
        r.pbits = {s.pbits[17:0], 1'b0};
        return r;
    endfunction

endpackage

// ===== design/strauss_surface_coefficients_unit.sv =====
// Strauss surface coefficient unit: reflection vector, transmittance and
// specular reflectance per ray hit, fully pipelined. Depends on ssc_pkg.
//
//  Channel  | Ports                         | Payload
//  ---------+-------------------------------+-----------------------------------
//  input    | s_axis_tvalid/tready/tdata    | smoothness, opacity, dir, norm, d.n
//  result   | m_axis_tvalid/tready/tdata/tuser | refl xyz, transmit, specular, fault
//
// One beat enters per cycle while the result channel is not stalled; each result passes
// through six arithmetic stages, one divider setup stage, 19 one-bit division stages and
// the output register. The divider chain makes up most of the pipeline depth.
// Reset (aresetn low, synchronous) clears all valid bits.
// A stalled result holds the whole pipeline in place; nothing is lost or repeated.
module strauss_surface_coefficients_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // smoothness[16:0], opacity[33:17], dir_x[49:34], dir_y[65:50], dir_z[81:66],
    // norm_x[97:82], norm_y[113:98], norm_z[129:114], dir_dot_norm[145:130], zeros
    input  logic [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // refl_x[15:0], refl_y[31:16], refl_z[47:32], transmit[67:48], specular[87:68]
    output logic [87:0]  m_axis_tdata,
    // divide_fault[0]
    output logic [0:0]   m_axis_tuser
);

    logic en;
    logic [ssc_pkg::FRONT_STAGES-1:0] fv_reg;
    logic [ssc_pkg::DIV_STEPS:0]      dvld_reg;
    logic                             out_vld_reg;

    assign en            = ~out_vld_reg | m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_vld_reg;

    // Input unpacking and clamping of the Q1.16 fractions.
    logic [16:0] sm_in, op_in, sm_c, op_c;
    logic signed [15:0] d_in [3];
    logic signed [15:0] n_in [3];
    logic signed [15:0] dn_in;

    always_comb begin
        sm_in = s_axis_tdata[16:0];
        op_in = s_axis_tdata[33:17];
        d_in[0] = s_axis_tdata[49:34];
        d_in[1] = s_axis_tdata[65:50];
        d_in[2] = s_axis_tdata[81:66];
        n_in[0] = s_axis_tdata[97:82];
        n_in[1] = s_axis_tdata[113:98];
        n_in[2] = s_axis_tdata[129:114];
        dn_in   = s_axis_tdata[145:130];
        sm_c = (sm_in > ssc_pkg::Q16_ONE) ? ssc_pkg::Q16_ONE : sm_in;
        op_c = (op_in > ssc_pkg::Q16_ONE) ? ssc_pkg::Q16_ONE : op_in;
    end

    // Stage 1: S squared and the normal scaled by d.n.
    logic [16:0] s2_1_reg, sm_1_reg, op_1_reg;
    logic signed [18:0] nd_1_reg [3];
    logic signed [15:0] d_1_reg [3];
    logic [33:0] sq_1;
    logic signed [31:0] ndp_1 [3];

    always_comb begin
        sq_1 = sm_c * sm_c;
        for (int i = 0; i < 3; i++) begin
            ndp_1[i] = n_in[i] * dn_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_1_reg <= sq_1[32:16];
            sm_1_reg <= sm_c;
            op_1_reg <= op_c;
            for (int i = 0; i < 3; i++) begin
                nd_1_reg[i] <= ndp_1[i][31:13];
                d_1_reg[i]  <= d_in[i];
            end
        end
    end

    // Stage 2: S cubed and the saturated reflection vector.
    logic [16:0] s3_2_reg, op_2_reg, iop_2_reg;
    logic signed [15:0] d_2_reg [3];
    logic signed [15:0] r_2_reg [3];
    logic [33:0] cube_2;
    logic signed [19:0] rsum_2 [3];
    logic signed [15:0] rsat_2 [3];

    always_comb begin
        cube_2 = s2_1_reg * sm_1_reg;
        for (int i = 0; i < 3; i++) begin
            rsum_2[i] = 20'(d_1_reg[i]) + 20'(nd_1_reg[i]);
            if (rsum_2[i] > 20'sd32767) begin
                rsat_2[i] = 16'sh7fff;
            end else if (rsum_2[i] < -20'sd32768) begin
                rsat_2[i] = 16'sh8000;
            end else begin
                rsat_2[i] = rsum_2[i][15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_2_reg  <= cube_2[32:16];
            op_2_reg  <= op_1_reg;
            iop_2_reg <= 17'(ssc_pkg::Q16_ONE - op_1_reg);
            for (int i = 0; i < 3; i++) begin
                d_2_reg[i] <= d_1_reg[i];
                r_2_reg[i] <= rsat_2[i];
            end
        end
    end

    // Stage 3: diffuse reflectivity and the terms of d.r.
    logic [16:0] dif_3_reg, op_3_reg, iop_3_reg;
    logic signed [31:0] dp_3_reg [3];
    logic signed [15:0] r_3_reg [3];
    logic [33:0] difp_3;

    always_comb begin
        difp_3 = 17'(ssc_pkg::Q16_ONE - s3_2_reg) * iop_2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dif_3_reg <= difp_3[32:16];
            op_3_reg  <= op_2_reg;
            iop_3_reg <= iop_2_reg;
            for (int i = 0; i < 3; i++) begin
                dp_3_reg[i] <= d_2_reg[i] * r_2_reg[i];
                r_3_reg[i]  <= r_2_reg[i];
            end
        end
    end

    // Stage 4: residual reflectivity and U = 1 - |d.r|.
    logic [16:0] res_4_reg, dif_4_reg, op_4_reg;
    logic signed [20:0] u_4_reg;
    logic signed [15:0] r_4_reg [3];
    logic signed [33:0] dot_4;
    logic signed [21:0] dsh_4, mag_4;
    logic signed [22:0] u_4;

    always_comb begin
        dot_4 = 34'(dp_3_reg[0]) + 34'(dp_3_reg[1]) + 34'(dp_3_reg[2]);
        dsh_4 = dot_4[33:12];
        mag_4 = dsh_4[21] ? -dsh_4 : dsh_4;
        u_4   = 23'sd65536 - 23'(mag_4);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_4_reg <= 17'(iop_3_reg - dif_3_reg);
            dif_4_reg <= dif_3_reg;
            op_4_reg  <= op_3_reg;
            u_4_reg   <= u_4[20:0];
            for (int i = 0; i < 3; i++) begin
                r_4_reg[i] <= r_3_reg[i];
            end
        end
    end

    // Stage 5: K = U * N and the divisor 1 - N.
    logic signed [20:0] k_5_reg;
    logic [16:0] den_5_reg, dif_5_reg, op_5_reg;
    logic signed [15:0] r_5_reg [3];
    logic signed [38:0] kp_5;

    always_comb begin
        kp_5 = 39'(u_4_reg) * 39'(signed'({1'b0, res_4_reg}));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_5_reg   <= kp_5[36:16];
            den_5_reg <= 17'(ssc_pkg::Q16_ONE - res_4_reg);
            dif_5_reg <= dif_4_reg;
            op_5_reg  <= op_4_reg;
            for (int i = 0; i < 3; i++) begin
                r_5_reg[i] <= r_4_reg[i];
            end
        end
    end

    // Stage 6: dividend (1 - K) * O.
    logic [35:0] p_6_reg;
    logic [16:0] den_6_reg, dif_6_reg;
    logic signed [15:0] r_6_reg [3];
    logic signed [21:0] num_6;
    logic [36:0] pp_6;

    always_comb begin
        num_6 = 22'sd65536 - 22'(k_5_reg);
        pp_6  = num_6[19:0] * op_5_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_6_reg   <= pp_6[35:0];
            den_6_reg <= den_5_reg;
            dif_6_reg <= dif_5_reg;
            for (int i = 0; i < 3; i++) begin
                r_6_reg[i] <= r_5_reg[i];
            end
        end
    end

    // Divider setup, saturation check, then one quotient bit per stage.
    ssc_pkg::div_stage_t div_reg [ssc_pkg::DIV_STEPS+1];
    ssc_pkg::div_stage_t div_init;

    always_comb begin
        div_init.rem     = p_6_reg[35:19];
        div_init.pbits   = p_6_reg[18:0];
        div_init.quo     = '0;
        div_init.den     = den_6_reg;
        div_init.diffuse = dif_6_reg;
        div_init.sat     = (p_6_reg >= {den_6_reg, 19'd0});
        div_init.fault   = (den_6_reg == 17'd0);
        div_init.rx      = r_6_reg[0];
        div_init.ry      = r_6_reg[1];
        div_init.rz      = r_6_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg[0] <= div_init;
            for (int i = 1; i <= ssc_pkg::DIV_STEPS; i++) begin
                div_reg[i] <= ssc_pkg::div_step(div_reg[i-1]);
            end
        end
    end

    // Output stage: transmittance and specular reflectance.
    ssc_pkg::div_stage_t last;
    logic signed [19:0] trans;
    logic signed [21:0] spec_w;
    logic signed [19:0] spec;
    logic [87:0] data_reg;
    logic        fault_reg;

    always_comb begin
        last = div_reg[ssc_pkg::DIV_STEPS];
        if (last.sat || last.fault) begin
            trans = ssc_pkg::T_MAX;
        end else begin
            trans = signed'({1'b0, last.quo});
        end
        spec_w = 22'sd65536 - 22'(trans) - 22'(signed'({1'b0, last.diffuse}));
        if (spec_w > 22'(ssc_pkg::T_MAX)) begin
            spec = ssc_pkg::T_MAX;
        end else if (spec_w < 22'(ssc_pkg::T_MIN)) begin
            spec = ssc_pkg::T_MIN;
        end else begin
            spec = spec_w[19:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg  <= {spec, trans, last.rz, last.ry, last.rx};
            fault_reg <= last.fault;
        end
    end

    assign m_axis_tdata    = data_reg;
    assign m_axis_tuser[0] = fault_reg;

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg      <= '0;
            dvld_reg    <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            fv_reg      <= {fv_reg[ssc_pkg::FRONT_STAGES-2:0], s_axis_tvalid};
            dvld_reg    <= {dvld_reg[ssc_pkg::DIV_STEPS-1:0],
                            fv_reg[ssc_pkg::FRONT_STAGES-1]};
            out_vld_reg <= dvld_reg[ssc_pkg::DIV_STEPS];
        end
    end

endmodule
